/* sv/ecdf_pkg.sv */
// Package for the empirical CDF interpolation sampler.
// Holds field widths, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ecdf_pkg;

	localparam int VALUE_BITS      = 32;
	localparam int UNIFORM_BITS    = 32;
	localparam int STORE_DEPTH_DEF = 1024;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FEW  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_CHK,
		ST_LD_CMP,
		ST_DR_MUL,
		ST_DR_ADDR,
		ST_DR_DIFF,
		ST_DR_SUM,
		ST_RESULT
	} st_t;

endpackage

`default_nettype wire

/* sv/empirical_cdf_interp_sampler.sv */
// Empirical CDF sampler: sorted observation store with insertion and
// linear-interpolation draws. Depends on ecdf_pkg.
//
// channel | signals                                   | role
// req     | req_valid, req_stall, op, start_new,      | load or draw request in
//         | observation, uniform_fraction             |
// rsp     | rsp_valid, rsp_stall, status, variate     | one result per request out
//
// A draw goes from acceptance to the result register through one multiply
// for the interval, one dual-port store read, one multiply for the offset, one add.
// A load into an empty store writes the entry directly; else it moves past each
// larger entry (at most STORE_DEPTH-1), one entry moved per cycle through the
// single write port. A full-store load or a short draw goes straight to the result.
// Reset clears the count and the control; the store needs no clearing pass.
// A stalled result stays in the output register; the next request is taken meanwhile.
`default_nettype none

module empirical_cdf_interp_sampler #(
	parameter int STORE_DEPTH = ecdf_pkg::STORE_DEPTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    req_valid,
	output logic                                   req_stall,
	input  wire                                    op,
	input  wire                                    start_new,
	input  wire signed [ecdf_pkg::VALUE_BITS-1:0]  observation,
	input  wire        [ecdf_pkg::UNIFORM_BITS-1:0] uniform_fraction,
	output logic                                   rsp_valid,
	input  wire                                    rsp_stall,
	output logic       [1:0]                       status,
	output logic signed [ecdf_pkg::VALUE_BITS-1:0] variate
);

	import ecdf_pkg::*;

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PW = UNIFORM_BITS + CW;
	localparam int MW = VALUE_BITS + UNIFORM_BITS;

	logic [VALUE_BITS-1:0] mem [STORE_DEPTH];

	st_t                   state_q, state_d;
	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	logic [1:0]            rsp_status_q;
	logic [VALUE_BITS-1:0] rsp_variate_q;

	logic [IW-1:0]           ptr_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [UNIFORM_BITS-1:0] u_q;
	logic [PW-1:0]           prod1_q;
	logic [UNIFORM_BITS-1:0] f_q;
	logic [MW-1:0]           prod2_q;
	logic [VALUE_BITS-1:0]   lo_q;
	logic [1:0]              res_status_q;
	logic [VALUE_BITS-1:0]   res_variate_q;

	logic [VALUE_BITS-1:0] rdata_a, rdata_b;
	logic                  we;
	logic [IW-1:0]         waddr, raddr_a, raddr_b;
	logic [VALUE_BITS-1:0] wdata;

	logic                  accept, out_free, shift_go;
	logic [CW-1:0]         cnt_eff, cnt_m2, j_raw, j_cl;
	logic [IW-1:0]         idx;
	logic [VALUE_BITS-1:0] diff;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign cnt_eff  = start_new ? '0 : count_q;
	assign shift_go = $signed(rdata_a) > $signed(val_q);
	assign cnt_m2   = count_q - CW'(2);
	assign j_raw    = prod1_q[PW-1:UNIFORM_BITS];
	assign j_cl     = (j_raw > cnt_m2) ? cnt_m2 : j_raw;
	assign idx      = j_cl[IW-1:0];
	assign diff     = rdata_b - rdata_a;

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign variate   = rsp_variate_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == 1'b0) begin
						state_d = (cnt_eff == CW'(STORE_DEPTH)) ? ST_RESULT : ST_LD_CHK;
					end else begin
						state_d = (count_q < CW'(2)) ? ST_RESULT : ST_DR_MUL;
					end
				end
			end
			ST_LD_CHK:  state_d = (ptr_q == '0) ? ST_RESULT : ST_LD_CMP;
			ST_LD_CMP: begin
				if (shift_go) begin
					state_d = (ptr_q == IW'(1)) ? ST_LD_CHK : ST_LD_CMP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_DR_MUL:  state_d = ST_DR_ADDR;
			ST_DR_ADDR: state_d = ST_DR_DIFF;
			ST_DR_DIFF: state_d = ST_DR_SUM;
			ST_DR_SUM:  state_d = ST_RESULT;
			ST_RESULT:  state_d = out_free ? ST_IDLE : ST_RESULT;
			default:    state_d = ST_IDLE;
		endcase
	end

	// store port control
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		we        = 1'b0;
		waddr     = ptr_q;
		wdata     = val_q;
		raddr_a   = ptr_q - IW'(1);
		raddr_b   = ptr_q;
		case (state_q)
			ST_LD_CHK: begin
				if (ptr_q == '0) begin
					we = 1'b1;
				end
			end
			ST_LD_CMP: begin
				we      = 1'b1;
				raddr_a = ptr_q - IW'(2);
				if (shift_go) begin
					wdata = rdata_a;
				end
			end
			ST_DR_ADDR: begin
				raddr_a = idx;
				raddr_b = idx + IW'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op == 1'b0 && cnt_eff != CW'(STORE_DEPTH)) begin
				count_q <= cnt_eff + CW'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_q         <= cnt_eff[IW-1:0];
			val_q         <= observation;
			u_q           <= uniform_fraction;
			res_variate_q <= '0;
			if (op == 1'b0) begin
				res_status_q <= (cnt_eff == CW'(STORE_DEPTH)) ? STATUS_FULL : STATUS_OK;
			end else begin
				res_status_q <= (count_q < CW'(2)) ? STATUS_FEW : STATUS_OK;
			end
		end
		if (state_q == ST_LD_CMP && shift_go) begin
			ptr_q <= ptr_q - IW'(1);
		end
		if (state_q == ST_DR_MUL) begin
			prod1_q <= PW'(u_q) * PW'(count_q - CW'(1));
		end
		if (state_q == ST_DR_ADDR) begin
			f_q <= prod1_q[UNIFORM_BITS-1:0];
		end
		if (state_q == ST_DR_DIFF) begin
			prod2_q <= MW'(diff) * MW'(f_q);
			lo_q    <= rdata_a;
		end
		if (state_q == ST_DR_SUM) begin
			res_variate_q <= lo_q + prod2_q[MW-1:UNIFORM_BITS];
		end
		if (state_q == ST_RESULT && out_free) begin
			rsp_status_q  <= res_status_q;
			rsp_variate_q <= res_variate_q;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("observation count beyond store depth");

	a_cmp_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LD_CMP |-> ptr_q != '0)
		else $error("insert compare with empty prefix");

	a_draw_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DR_ADDR |-> count_q >= CW'(2))
		else $error("draw read with fewer than two observations");

	a_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_LD_CHK || state_q == ST_LD_CMP))
		else $error("store write outside a load");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result raised outside result state");

endmodule

`default_nettype wire
